[sv/v3a_pkg.sv]
// ---------------------------------------------------------------------------
// v3a_pkg: shared types and helpers for the vector arithmetic unit
// Operation codes, fixed-point constants, pipeline item types and rounding.
// ---------------------------------------------------------------------------
package v3a_pkg;

  localparam int FRAC_BITS = 16;
  localparam int SQRT_STAGES = 32;

  localparam logic [2:0] OP_ADD    = 3'd0;
  localparam logic [2:0] OP_SUB    = 3'd1;
  localparam logic [2:0] OP_NEGATE = 3'd2;
  localparam logic [2:0] OP_SCALE  = 3'd3;
  localparam logic [2:0] OP_CROSS  = 3'd4;
  localparam logic [2:0] OP_DOT    = 3'd5;
  localparam logic [2:0] OP_LENGTH = 3'd6;
  localparam logic [2:0] OP_EQUAL  = 3'd7;

  localparam logic signed [65:0] HALF_LSB = 66'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [65:0] MAX32_W  = 66'sd2147483647;
  localparam logic signed [65:0] MIN32_W  = -66'sd2147483648;

  typedef struct packed {
    logic signed [63:0] p0;
    logic signed [63:0] p1;
    logic signed [31:0] r;
    logic               sat;
    logic        [32:0] ad;
  } v3a_lane_t;

  typedef struct packed {
    logic [2:0]         op;
    logic signed [31:0] rx;
    logic signed [31:0] ry;
    logic signed [31:0] rz;
    logic signed [31:0] sc;
    logic               eq;
    logic               sat;
    logic [63:0]        s;
    logic [34:0]        rem;
    logic [31:0]        root;
  } v3a_item_t;

  function automatic logic [32:0] sat_narrow(input logic signed [32:0] v);
    logic [32:0] res;
    begin
      if (v > 33'sd2147483647) begin
        res = {1'b1, 32'h7FFF_FFFF};
      end else if (v < -33'sd2147483648) begin
        res = {1'b1, 32'h8000_0000};
      end else begin
        res = {1'b0, v[31:0]};
      end
      return res;
    end
  endfunction

  function automatic logic [32:0] round_sat(input logic signed [65:0] v);
    logic signed [65:0] q;
    logic [32:0]        res;
    begin
      q = (v + HALF_LSB) >>> FRAC_BITS;
      if (q > MAX32_W) begin
        res = {1'b1, 32'h7FFF_FFFF};
      end else if (q < MIN32_W) begin
        res = {1'b1, 32'h8000_0000};
      end else begin
        res = {1'b0, q[31:0]};
      end
      return res;
    end
  endfunction

endpackage

[sv/v3a_lane.sv]
// ---------------------------------------------------------------------------
// v3a_lane: one component lane
// Forms the lane's products, the saturated add, subtract or negate, and the
// absolute difference, all registered.
// ---------------------------------------------------------------------------
module v3a_lane (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic [2:0]           op,
  input  logic signed [31:0]   a,
  input  logic signed [31:0]   b,
  input  logic signed [31:0]   k,
  input  logic signed [31:0]   a_next,
  input  logic signed [31:0]   b_next,
  input  logic signed [31:0]   a_prev,
  input  logic signed [31:0]   b_prev,
  output logic                 out_valid,
  output v3a_pkg::v3a_lane_t   res
);
  import v3a_pkg::*;

  logic signed [31:0] m0a, m0b;
  logic signed [32:0] lin;
  logic [32:0]        lin_sat;
  logic signed [32:0] diff;
  v3a_lane_t          res_next;

  always_comb begin
    unique case (op)
      OP_CROSS: begin
        m0a = a_next;
        m0b = b_prev;
      end
      OP_SCALE: begin
        m0a = a;
        m0b = k;
      end
      OP_LENGTH: begin
        m0a = a;
        m0b = a;
      end
      default: begin
        m0a = a;
        m0b = b;
      end
    endcase
    unique case (op)
      OP_ADD:    lin = {a[31], a} + {b[31], b};
      OP_SUB:    lin = {a[31], a} - {b[31], b};
      OP_NEGATE: lin = -{a[31], a};
      default:   lin = '0;
    endcase
    lin_sat = sat_narrow(lin);
    diff = {a[31], a} - {b[31], b};
    res_next.p0 = m0a * m0b;
    res_next.p1 = a_prev * b_next;
    res_next.r = lin_sat[31:0];
    res_next.sat = lin_sat[32];
    res_next.ad = diff[32] ? 33'(-diff) : 33'(diff);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res <= res_next;
    end
  end

endmodule

[sv/v3a_merge.sv]
// ---------------------------------------------------------------------------
// v3a_merge: lane merge
// Sums lane products, then rounds, saturates and compares against the
// tolerance over two register stages.
// ---------------------------------------------------------------------------
module v3a_merge (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  logic [2:0]          op,
  input  v3a_pkg::v3a_lane_t  lx,
  input  v3a_pkg::v3a_lane_t  ly,
  input  v3a_pkg::v3a_lane_t  lz,
  input  logic [30:0]         tolerance,
  output logic                out_valid,
  output v3a_pkg::v3a_item_t  item
);
  import v3a_pkg::*;

  logic               valid_a;
  logic [2:0]         op_a;
  logic signed [65:0] tx, ty, tz, tsum;
  logic [34:0]        dsum;
  logic signed [31:0] rx_a, ry_a, rz_a;
  logic               sat_a;
  logic [32:0]        qx, qy, qz, qs;
  v3a_item_t          item_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      valid_a <= in_valid;
      out_valid <= valid_a;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op_a <= op;
      if (op == OP_CROSS) begin
        tx <= 66'(lx.p0) - 66'(lx.p1);
        ty <= 66'(ly.p0) - 66'(ly.p1);
        tz <= 66'(lz.p0) - 66'(lz.p1);
      end else begin
        tx <= 66'(lx.p0);
        ty <= 66'(ly.p0);
        tz <= 66'(lz.p0);
      end
      tsum <= 66'(lx.p0) + 66'(ly.p0) + 66'(lz.p0);
      dsum <= 35'(lx.ad) + 35'(ly.ad) + 35'(lz.ad);
      rx_a <= lx.r;
      ry_a <= ly.r;
      rz_a <= lz.r;
      sat_a <= lx.sat | ly.sat | lz.sat;
    end
  end

  always_comb begin
    qx = round_sat(tx);
    qy = round_sat(ty);
    qz = round_sat(tz);
    qs = round_sat(tsum);
    item_next = '0;
    item_next.op = op_a;
    item_next.s = tsum[63:0];
    unique case (op_a)
      OP_ADD, OP_SUB, OP_NEGATE: begin
        item_next.rx = rx_a;
        item_next.ry = ry_a;
        item_next.rz = rz_a;
        item_next.sat = sat_a;
      end
      OP_SCALE, OP_CROSS: begin
        item_next.rx = qx[31:0];
        item_next.ry = qy[31:0];
        item_next.rz = qz[31:0];
        item_next.sat = qx[32] | qy[32] | qz[32];
      end
      OP_DOT: begin
        item_next.sc = qs[31:0];
        item_next.sat = qs[32];
      end
      OP_LENGTH: begin
        item_next.sat = 1'b0;
      end
      default: begin
        item_next.eq = (dsum <= 35'(tolerance));
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      item <= item_next;
    end
  end

endmodule

[sv/v3a_sqrt_stage.sv]
// ---------------------------------------------------------------------------
// v3a_sqrt_stage: one step of the square root pipeline
// Brings in two radicand bits and settles one root bit.
// ---------------------------------------------------------------------------
module v3a_sqrt_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  v3a_pkg::v3a_item_t in_item,
  output logic               out_valid,
  output v3a_pkg::v3a_item_t out_item
);
  import v3a_pkg::*;

  logic [34:0] rem_sh;
  logic [34:0] trial;
  v3a_item_t   item_next;

  always_comb begin
    rem_sh = {in_item.rem[32:0], in_item.s[63:62]};
    trial = {1'b0, in_item.root, 2'b01};
    item_next = in_item;
    item_next.s = {in_item.s[61:0], 2'b00};
    if (rem_sh >= trial) begin
      item_next.rem = rem_sh - trial;
      item_next.root = {in_item.root[30:0], 1'b1};
    end else begin
      item_next.rem = rem_sh;
      item_next.root = {in_item.root[30:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_item <= item_next;
    end
  end

endmodule

[sv/vector3_arith_unit.sv]
// ---------------------------------------------------------------------------
// vector3_arith_unit: three-component Q16.16 vector ALU
// Add, subtract, negate, scale, cross, dot, length and tolerance equality.
// ---------------------------------------------------------------------------
// The unit takes one word per cycle while s_tready is high and returns one result
// word per input word, in order, through one lane multiply stage, two merge
// stages, 32 square root stages and the output register. Every operation
// passes the square root pipeline, one root bit per stage. The whole pipeline
// holds while a result waits on the output, so s_tready follows m_tready.
module vector3_arith_unit (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // a_x, a_y, a_z, b_x, b_y, b_z, scale_factor
  input  logic [223:0] s_tdata,
  // op
  input  logic [2:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // r_x, r_y, r_z, scalar_result, is_equal, saturated, zero fill
  output logic [135:0] m_tdata,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import v3a_pkg::*;

  logic [30:0]        equal_tolerance;
  logic               en;
  logic signed [31:0] ax, ay, az, bx, by, bz, k;
  logic               lv_x, lv_y, lv_z, mv;
  logic [2:0]         op_l;
  v3a_lane_t          lx, ly, lz;
  v3a_item_t          mitem;
  logic               sv [SQRT_STAGES+1];
  v3a_item_t          si [SQRT_STAGES+1];
  logic [32:0]        len;
  v3a_item_t          fin;
  v3a_item_t          fin_next;

  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : {1'b0, equal_tolerance};

  always_ff @(posedge clk) begin
    if (rst) begin
      equal_tolerance <= '0;
    end else if (psel && penable && pwrite && pready && !paddr[2]) begin
      equal_tolerance <= pwdata[30:0];
    end
  end

  assign en = !m_tvalid || m_tready;
  assign s_tready = en;

  assign ax = s_tdata[31:0];
  assign ay = s_tdata[63:32];
  assign az = s_tdata[95:64];
  assign bx = s_tdata[127:96];
  assign by = s_tdata[159:128];
  assign bz = s_tdata[191:160];
  assign k  = s_tdata[223:192];

  v3a_lane u_lane_x (
    .clk(clk), .rst(rst), .en(en), .in_valid(s_tvalid), .op(s_tuser),
    .a(ax), .b(bx), .k(k), .a_next(ay), .b_next(by), .a_prev(az), .b_prev(bz),
    .out_valid(lv_x), .res(lx)
  );

  v3a_lane u_lane_y (
    .clk(clk), .rst(rst), .en(en), .in_valid(s_tvalid), .op(s_tuser),
    .a(ay), .b(by), .k(k), .a_next(az), .b_next(bz), .a_prev(ax), .b_prev(bx),
    .out_valid(lv_y), .res(ly)
  );

  v3a_lane u_lane_z (
    .clk(clk), .rst(rst), .en(en), .in_valid(s_tvalid), .op(s_tuser),
    .a(az), .b(bz), .k(k), .a_next(ax), .b_next(bx), .a_prev(ay), .b_prev(by),
    .out_valid(lv_z), .res(lz)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      op_l <= s_tuser;
    end
  end

  v3a_merge u_merge (
    .clk(clk), .rst(rst), .en(en), .in_valid(lv_x & lv_y & lv_z), .op(op_l),
    .lx(lx), .ly(ly), .lz(lz), .tolerance(equal_tolerance),
    .out_valid(mv), .item(mitem)
  );

  always_comb begin
    sv[0] = mv;
    si[0] = mitem;
    si[0].rem = '0;
    si[0].root = '0;
  end

  for (genvar g = 0; g < SQRT_STAGES; g++) begin : g_sqrt
    v3a_sqrt_stage u_stage (
      .clk(clk), .rst(rst), .en(en), .in_valid(sv[g]), .in_item(si[g]),
      .out_valid(sv[g+1]), .out_item(si[g+1])
    );
  end

  always_comb begin
    len = {1'b0, si[SQRT_STAGES].root}
        + 33'(si[SQRT_STAGES].rem > {3'b000, si[SQRT_STAGES].root});
  end

  always_comb begin
    fin_next = si[SQRT_STAGES];
    if (si[SQRT_STAGES].op == OP_LENGTH) begin
      if (len[32] || len[31]) begin
        fin_next.sc = 32'h7FFF_FFFF;
        fin_next.sat = 1'b1;
      end else begin
        fin_next.sc = len[31:0];
        fin_next.sat = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= sv[SQRT_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fin <= fin_next;
    end
  end

  assign m_tdata = {6'd0, fin.sat, fin.eq, fin.sc, fin.rz, fin.ry, fin.rx};

endmodule

[sv/v3a_checker.sv]
// ---------------------------------------------------------------------------
// v3a_checker: port-level checks for the vector arithmetic unit
// Watches the stream and register ports of the top level.
// ---------------------------------------------------------------------------
module v3a_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [135:0] m_tdata,
  input logic         psel,
  input logic         penable,
  input logic         pwrite,
  input logic [2:0]   paddr,
  input logic [31:0]  pwdata,
  input logic [31:0]  prdata
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result word changed while stalled");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready))
    else $error("input ready does not follow output stall");

  a_eq_clean: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[128] |-> !m_tdata[129] && m_tdata[127:0] == 128'd0)
    else $error("equal verdict with nonzero values or saturation");

  a_readback: assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite && !paddr[2] |=>
      (paddr[2] || prdata == {1'b0, $past(pwdata[30:0])}))
    else $error("tolerance register read back wrong");

endmodule

bind vector3_arith_unit v3a_checker u_v3a_checker (
  .clk(clk), .rst(rst), .s_tready(s_tready), .m_tvalid(m_tvalid),
  .m_tready(m_tready), .m_tdata(m_tdata), .psel(psel), .penable(penable),
  .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata)
);
